[sv/rarc_pkg.sv]
// rarc_pkg: shared types and codes for the ring all-reduce transfer checker
// no dependencies; imported by every module of the block
package rarc_pkg;

  // operation codes on the input beat
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;

  // classified item kinds travelling through the queue
  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_SEND  = 2'd1;
  localparam logic [1:0] KIND_RECV  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_AHEAD    = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_INDEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_RING_POS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_RING_POS = 3'd6;
  localparam int CFG_DATA_W = 31;

  // fixed numbers of the slicing scheme
  localparam int MIN_SLICE    = 8192;
  localparam int SIZE_MAX_OUT = 4194303;
  localparam logic signed [22:0] EXP_NONE = -23'sd1;

  // shared divider widths
  localparam int DDW = 32;
  localparam int DVW = 16;

  // queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [21:0] size;
  } in_item_t;

  typedef struct packed {
    logic signed [22:0] expected_size;
    logic [1:0]         status;
    logic               all_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] size;
  } qitem_t;

  typedef struct packed {
    logic [6:0]  rank_count;
    logic [5:0]  channel_count;
    logic [4:0]  channel_index;
    logic [10:0] thread_count;
    logic [30:0] element_count;
    logic [5:0]  send_ring_position;
    logic [5:0]  recv_ring_position;
  } cfg_t;

  typedef struct packed {
    logic           start;
    logic [DDW-1:0] dividend;
    logic [DVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DDW-1:0] quot;
    logic [DVW-1:0] rem;
  } div_rsp_t;

endpackage

[sv/rarc_front.sv]
// rarc_front: takes input beats, classifies the operation and holds the item
// until the queue has room; depends on rarc_pkg
module rarc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rarc_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output rarc_pkg::qitem_t  push_data
);
  import rarc_pkg::*;

  logic   hold_valid_r, hold_valid_nxt;
  qitem_t hold_r, hold_nxt;
  qitem_t cls;

  // classify: unused operation code behaves as a query
  always_comb begin
    cls.size = in_item.size;
    case (in_item.operation)
      OP_SEND: cls.kind = KIND_SEND;
      OP_RECV: cls.kind = KIND_RECV;
      default: cls.kind = KIND_QUERY;
    endcase
  end

  assign busy      = hold_valid_r;
  assign push      = hold_valid_r & ~q_full;
  assign push_data = hold_r;

  // holding stage
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (start && !hold_valid_r) begin
      hold_valid_nxt = 1'b1;
      hold_nxt       = cls;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

[sv/rarc_queue.sv]
// rarc_queue: short fifo of classified items between front and back
// depends on rarc_pkg
module rarc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rarc_pkg::qitem_t push_data,
  input  logic             pop,
  output rarc_pkg::qitem_t head,
  output logic             full,
  output logic             empty
);
  import rarc_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  qitem_t          ent_r [QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNTW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

[sv/rarc_div.sv]
// rarc_div: shared restoring divider, one quotient bit per cycle
// depends on rarc_pkg
module rarc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rarc_pkg::div_req_t req,
  output rarc_pkg::div_rsp_t rsp
);
  import rarc_pkg::*;

  localparam int CW = $clog2(DDW);

  logic           busy_r, done_r;
  logic [CW-1:0]  cnt_r;
  logic [DDW-1:0] quo_r;
  logic [DVW-1:0] rem_r, dvs_r;
  logic [DVW:0]   sh, diff;
  logic           ge;

  // one trial subtraction
  assign sh   = {rem_r, quo_r[DDW-1]};
  assign ge   = (sh >= {1'b0, dvs_r});
  assign diff = sh - {1'b0, dvs_r};

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DDW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DDW-2:0], ge};
      rem_r <= ge ? diff[DVW-1:0] : sh[DVW-1:0];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("divider done without a run");

endmodule

[sv/rarc_back.sv]
// rarc_back: sequencer that works out expected sizes, checks reports and
// moves the send and receive cursors; depends on rarc_pkg and rarc_div
module rarc_back #(
  parameter int MAX_RANKS      = 64,
  parameter int CHUNK_ELEMENTS = 524288
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rarc_pkg::cfg_t      cfg,
  input  rarc_pkg::qitem_t    q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_strobe,
  output rarc_pkg::out_item_t out_item
);
  import rarc_pkg::*;

  localparam int NW   = $clog2(MAX_RANKS + 1);
  localparam int SW   = $clog2(2 * MAX_RANKS - 2);
  localparam int PW   = 6 + NW;
  localparam int CINW = 5 + NW;
  localparam int CW   = $clog2(CHUNK_ELEMENTS + 1);
  localparam int RCW  = CW + 1;
  localparam int OAW  = CINW + RCW;
  localparam int OBW  = NW + RCW;
  localparam int OFW  = ((OAW > 32) ? OAW : 32) + 2;
  localparam int GIW  = PW + CW;
  localparam int GSW  = ((GIW > 32) ? GIW : 32) + 1;
  localparam int SSW  = ((RCW + 1) > 14) ? (RCW + 1) : 14;

  // sequencer states
  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SSTEP = 4'd1;
  localparam logic [3:0] B_WSTEP = 4'd2;
  localparam logic [3:0] B_SRING = 4'd3;
  localparam logic [3:0] B_WRING = 4'd4;
  localparam logic [3:0] B_PREP  = 4'd5;
  localparam logic [3:0] B_SRC   = 4'd6;
  localparam logic [3:0] B_WRC   = 4'd7;
  localparam logic [3:0] B_SG    = 4'd8;
  localparam logic [3:0] B_WG    = 4'd9;
  localparam logic [3:0] B_MUL1  = 4'd10;
  localparam logic [3:0] B_MUL2  = 4'd11;
  localparam logic [3:0] B_OFF   = 4'd12;
  localparam logic [3:0] B_SLICE = 4'd13;
  localparam logic [3:0] B_FIN   = 4'd14;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rarc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic [3:0]     state_r, state_nxt;
  logic           sel_r, sel_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [21:0]    size_r, size_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [NW-1:0]  r_r, r_nxt, chunk_r, chunk_nxt;
  logic [PW-1:0]  per_r, per_nxt;
  logic [CINW-1:0] cin_r, cin_nxt;
  logic [11:0]    g_r, g_nxt;
  logic [CW-1:0]  rc_r, rc_nxt;
  logic [RCW-1:0] rcq_r, rcq_nxt, rc2_r, rc2_nxt, e_r, e_nxt;
  logic [OAW-1:0] offa_r, offa_nxt;
  logic [OBW-1:0] offb_r, offb_nxt;
  logic [GIW-1:0] ginc_r, ginc_nxt;
  logic [22:0]    bytes_r, bytes_nxt;
  logic           sat_r, sat_nxt;

  logic [31:0]    snd_grid_r, snd_grid_nxt, rcv_grid_r, rcv_grid_nxt;
  logic [SW-1:0]  snd_step_r, snd_step_nxt, rcv_step_r, rcv_step_nxt;
  logic           snd_half_r, snd_half_nxt, rcv_half_r, rcv_half_nxt;
  logic [31:0]    snd_taken_r, snd_taken_nxt, rcv_taken_r, rcv_taken_nxt;
  logic           done_r, done_nxt;
  logic           strobe_r, strobe_nxt;
  out_item_t      out_r, out_nxt;

  // effective configuration
  logic [NW-1:0]  n_c;
  logic [NW:0]    nsteps_c;
  logic [5:0]     nch_c;
  logic [10:0]    thr_c, thr_m32;
  logic [11:0]    g_c;
  logic [31:0]    elem_c;

  always_comb begin
    if (cfg.rank_count < 7'd2) begin
      n_c = NW'(2);
    end else if (32'(cfg.rank_count) > 32'(MAX_RANKS)) begin
      n_c = NW'(MAX_RANKS);
    end else begin
      n_c = NW'(cfg.rank_count);
    end
    nsteps_c = (NW + 1)'({n_c, 1'b0}) - (NW + 1)'(2);
    nch_c    = (cfg.channel_count == 6'd0) ? 6'd1 : cfg.channel_count;
    thr_c    = (cfg.thread_count < 11'd64) ? 11'd64 : cfg.thread_count;
    thr_m32  = thr_c - 11'd32;
    g_c      = {thr_m32, 1'b0};
    elem_c   = 32'(cfg.element_count);
  end

  // selected cursor
  logic [31:0]   cur_grid;
  logic [SW-1:0] cur_step;
  logic          cur_half;
  logic [5:0]    cur_ring;
  assign cur_grid = sel_r ? rcv_grid_r : snd_grid_r;
  assign cur_step = sel_r ? rcv_step_r : snd_step_r;
  assign cur_half = sel_r ? rcv_half_r : snd_half_r;
  assign cur_ring = sel_r ? cfg.recv_ring_position : cfg.send_ring_position;

  logic snd_used, rcv_used;
  assign snd_used = (snd_grid_r >= elem_c);
  assign rcv_used = (rcv_grid_r >= elem_c);

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DVW'(1);
    case (state_r)
      B_SSTEP: begin
        div_req.start    = 1'b1;
        div_req.dividend = DDW'(cur_step);
        div_req.divisor  = DVW'(nsteps_c);
      end
      B_SRING: begin
        div_req.start    = 1'b1;
        div_req.dividend = DDW'(cur_ring);
        div_req.divisor  = DVW'(n_c);
      end
      B_SRC: begin
        div_req.start    = 1'b1;
        div_req.dividend = elem_c - cur_grid;
        div_req.divisor  = DVW'(per_r);
      end
      B_SG: begin
        div_req.start    = 1'b1;
        div_req.dividend = DDW'(rc_r) + DDW'(g_r) - DDW'(1);
        div_req.divisor  = DVW'(g_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // chunk index within the ring step
  logic [NW+1:0] ct_a, ct_b;
  always_comb begin
    if ((NW + 2)'(s_r) < (NW + 2)'(n_c)) begin
      ct_a = (NW + 2)'(r_r) + (NW + 2)'(n_c) - (NW + 2)'(1) - (NW + 2)'(s_r);
    end else begin
      ct_a = (NW + 2)'(r_r) + (NW + 2)'({n_c, 1'b0}) - (NW + 2)'(1) - (NW + 2)'(s_r);
    end
    ct_b = (ct_a >= (NW + 2)'(n_c)) ? ct_a - (NW + 2)'(n_c) : ct_a;
  end

  // chunk rounding and offsets
  logic [31:0]    rc_up;
  logic [RCW+10:0] rc2_full;
  logic [OFW-1:0] off_c;
  logic [31:0]    ed_c;
  always_comb begin
    rc_up    = div_rsp.quot + 32'(div_rsp.rem != '0);
    rc2_full = (RCW + 11)'(rcq_r) * (RCW + 11)'(g_r);
    off_c    = OFW'(cur_grid) + OFW'(offa_r) + OFW'(offb_r);
    ed_c     = elem_c - 32'(off_c);
  end

  // slice sizes
  logic [SSW-1:0] e_w, ssb, ss_c, v_c;
  logic [SSW+1:0] b_c;
  always_comb begin
    e_w  = SSW'(e_r);
    ssb  = e_w + SSW'(31);
    ss_c = (ssb >> 5) << 4;
    if (ss_c < SSW'(MIN_SLICE)) begin
      ss_c = SSW'(MIN_SLICE);
    end
    if (!cur_half) begin
      v_c = (e_w < ss_c) ? e_w : ss_c;
    end else begin
      v_c = (e_w > ss_c) ? e_w - ss_c : '0;
    end
    b_c = {v_c, 2'b00};
  end

  // report check
  logic is_query, match;
  assign is_query = (kind_r == KIND_QUERY);
  assign match    = !sat_r && (bytes_r == {1'b0, size_r});

  // cursor advance helpers
  logic [SW:0]    snd_sinc, rcv_sinc;
  logic [GSW-1:0] snd_gs, rcv_gs;
  assign snd_sinc = (SW + 1)'(snd_step_r) + (SW + 1)'(1);
  assign rcv_sinc = (SW + 1)'(rcv_step_r) + (SW + 1)'(1);
  assign snd_gs   = GSW'(snd_grid_r) + GSW'(ginc_r);
  assign rcv_gs   = GSW'(rcv_grid_r) + GSW'(ginc_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    kind_nxt      = kind_r;
    size_nxt      = size_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    chunk_nxt     = chunk_r;
    per_nxt       = per_r;
    cin_nxt       = cin_r;
    g_nxt         = g_r;
    rc_nxt        = rc_r;
    rcq_nxt       = rcq_r;
    rc2_nxt       = rc2_r;
    e_nxt         = e_r;
    offa_nxt      = offa_r;
    offb_nxt      = offb_r;
    ginc_nxt      = ginc_r;
    bytes_nxt     = bytes_r;
    sat_nxt       = sat_r;
    snd_grid_nxt  = snd_grid_r;
    snd_step_nxt  = snd_step_r;
    snd_half_nxt  = snd_half_r;
    snd_taken_nxt = snd_taken_r;
    rcv_grid_nxt  = rcv_grid_r;
    rcv_step_nxt  = rcv_step_r;
    rcv_half_nxt  = rcv_half_r;
    rcv_taken_nxt = rcv_taken_r;
    done_nxt      = done_r;
    strobe_nxt    = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          kind_nxt = q_head.kind;
          size_nxt = q_head.size;
          sel_nxt  = (q_head.kind == KIND_RECV);
          out_nxt.expected_size = EXP_NONE;
          done_nxt = done_r | (snd_used & rcv_used);
          out_nxt.all_done = done_nxt;
          if (q_head.kind == KIND_QUERY) begin
            if (snd_taken_r > rcv_taken_r) begin
              out_nxt.status = ST_AHEAD;
              strobe_nxt     = 1'b1;
            end else if (snd_used) begin
              out_nxt.status = ST_FINISHED;
              strobe_nxt     = 1'b1;
            end else begin
              state_nxt = B_SSTEP;
            end
          end else if ((q_head.kind == KIND_RECV) ? rcv_used : snd_used) begin
            out_nxt.status = ST_FINISHED;
            strobe_nxt     = 1'b1;
          end else begin
            state_nxt = B_SSTEP;
          end
          if (!strobe_nxt) begin
            done_nxt = done_r;
          end
        end
      end
      B_SSTEP: state_nxt = B_WSTEP;
      B_WSTEP: begin
        if (div_rsp.done) begin
          s_nxt     = SW'(div_rsp.rem);
          state_nxt = B_SRING;
        end
      end
      B_SRING: state_nxt = B_WRING;
      B_WRING: begin
        if (div_rsp.done) begin
          r_nxt     = NW'(div_rsp.rem);
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        chunk_nxt = NW'(ct_b);
        per_nxt   = PW'(nch_c) * PW'(n_c);
        cin_nxt   = CINW'(cfg.channel_index) * CINW'(n_c);
        g_nxt     = g_c;
        state_nxt = B_SRC;
      end
      B_SRC: state_nxt = B_WRC;
      B_WRC: begin
        if (div_rsp.done) begin
          rc_nxt    = (rc_up > 32'(CHUNK_ELEMENTS)) ? CW'(CHUNK_ELEMENTS) : CW'(rc_up);
          state_nxt = B_SG;
        end
      end
      B_SG: state_nxt = B_WG;
      B_WG: begin
        if (div_rsp.done) begin
          rcq_nxt   = RCW'(div_rsp.quot);
          state_nxt = B_MUL1;
        end
      end
      B_MUL1: begin
        rc2_nxt   = RCW'(rc2_full);
        state_nxt = B_MUL2;
      end
      B_MUL2: begin
        offa_nxt  = OAW'(cin_r) * OAW'(rc2_r);
        offb_nxt  = OBW'(chunk_r) * OBW'(rc2_r);
        ginc_nxt  = GIW'(per_r) * GIW'(CHUNK_ELEMENTS);
        state_nxt = B_OFF;
      end
      B_OFF: begin
        if (off_c >= OFW'(elem_c)) begin
          e_nxt = '0;
        end else if (ed_c > 32'(rc2_r)) begin
          e_nxt = rc2_r;
        end else begin
          e_nxt = RCW'(ed_c);
        end
        state_nxt = B_SLICE;
      end
      B_SLICE: begin
        sat_nxt   = ((SSW + 2)'(b_c) > (SSW + 2)'(SIZE_MAX_OUT));
        bytes_nxt = sat_nxt ? 23'(SIZE_MAX_OUT) : 23'(b_c);
        state_nxt = B_FIN;
      end
      B_FIN: begin
        out_nxt.expected_size = $signed(bytes_r);
        out_nxt.status = (is_query || match) ? ST_OK : ST_MISMATCH;
        if (!is_query && match) begin
          if (!sel_r) begin
            if (snd_taken_r != '1) snd_taken_nxt = snd_taken_r + 32'd1;
            snd_half_nxt = ~snd_half_r;
            if (snd_half_r) begin
              if (32'(snd_sinc) >= 32'(nsteps_c)) begin
                snd_step_nxt = '0;
                snd_grid_nxt = (snd_gs > GSW'(32'hFFFF_FFFF)) ? '1 : 32'(snd_gs);
              end else begin
                snd_step_nxt = SW'(snd_sinc);
              end
            end
          end else begin
            if (rcv_taken_r != '1) rcv_taken_nxt = rcv_taken_r + 32'd1;
            rcv_half_nxt = ~rcv_half_r;
            if (rcv_half_r) begin
              if (32'(rcv_sinc) >= 32'(nsteps_c)) begin
                rcv_step_nxt = '0;
                rcv_grid_nxt = (rcv_gs > GSW'(32'hFFFF_FFFF)) ? '1 : 32'(rcv_gs);
              end else begin
                rcv_step_nxt = SW'(rcv_sinc);
              end
            end
          end
        end
        done_nxt = done_r | ((snd_grid_nxt >= elem_c) & (rcv_grid_nxt >= elem_c));
        out_nxt.all_done = done_nxt;
        strobe_nxt = 1'b1;
        state_nxt  = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      snd_grid_r  <= '0;
      snd_step_r  <= '0;
      snd_half_r  <= 1'b0;
      snd_taken_r <= '0;
      rcv_grid_r  <= '0;
      rcv_step_r  <= '0;
      rcv_half_r  <= 1'b0;
      rcv_taken_r <= '0;
      done_r      <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      snd_grid_r  <= snd_grid_nxt;
      snd_step_r  <= snd_step_nxt;
      snd_half_r  <= snd_half_nxt;
      snd_taken_r <= snd_taken_nxt;
      rcv_grid_r  <= rcv_grid_nxt;
      rcv_step_r  <= rcv_step_nxt;
      rcv_half_r  <= rcv_half_nxt;
      rcv_taken_r <= rcv_taken_nxt;
      done_r      <= done_nxt;
      strobe_r    <= strobe_nxt;
    end
    sel_r   <= sel_nxt;
    kind_r  <= kind_nxt;
    size_r  <= size_nxt;
    s_r     <= s_nxt;
    r_r     <= r_nxt;
    chunk_r <= chunk_nxt;
    per_r   <= per_nxt;
    cin_r   <= cin_nxt;
    g_r     <= g_nxt;
    rc_r    <= rc_nxt;
    rcq_r   <= rcq_nxt;
    rc2_r   <= rc2_nxt;
    e_r     <= e_nxt;
    offa_r  <= offa_nxt;
    offb_r  <= offb_nxt;
    ginc_r  <= ginc_nxt;
    bytes_r <= bytes_nxt;
    sat_r   <= sat_nxt;
    out_r   <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && $past(rst_n)) |-> ($past(state_r) == B_IDLE || $past(state_r) == B_FIN))
    else $error("result beat outside idle or finish");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(done_r)) |-> done_r)
    else $error("done flag dropped");

  a_taken_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (snd_taken_r >= $past(snd_taken_r)
                      && rcv_taken_r >= $past(rcv_taken_r)))
    else $error("taken counter went back");

endmodule

[sv/ring_allreduce_transfer_checker.sv]
// ring_allreduce_transfer_checker: top level, config registers and wiring
// depends on rarc_pkg, rarc_front, rarc_queue, rarc_back (with rarc_div)
//
// Usage:
//   Input: drive in_item with start high; the beat is taken on a clock edge
//   where start is high and busy is low. Operations are query next send
//   size, report a send and report a receive.
//   Result: one beat per input on out_item, marked by out_strobe for a
//   single cycle. The receiver cannot stall it and must take it then.
//   Config: cfg_valid/cfg_ready write channel with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no input is in flight.
//   Flow: a refused or finished item is answered straight from the idle
//   state; an item that needs a size takes four runs in turn of the shared
//   restoring divider (step and ring modulo, chunk split, chunk rounding).
//   Items are handled one at a time by the back end; a two-entry queue plus
//   a holding stage let up to three be taken ahead of it.
//   Reset (rst_n low, synchronous): cursors, counters, done flag cleared,
//   config back to its defaults, queue emptied.
module ring_allreduce_transfer_checker #(
  parameter int MAX_RANKS      = 64,
  parameter int CHUNK_ELEMENTS = 524288
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  rarc_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output rarc_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rarc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rarc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rarc_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   q_full, q_empty, q_push, q_pop;
  qitem_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RANK_COUNT:    cfg_nxt.rank_count         = cfg_data[6:0];
        CFG_CHANNEL_COUNT: cfg_nxt.channel_count      = cfg_data[5:0];
        CFG_CHANNEL_INDEX: cfg_nxt.channel_index      = cfg_data[4:0];
        CFG_THREAD_COUNT:  cfg_nxt.thread_count       = cfg_data[10:0];
        CFG_ELEMENT_COUNT: cfg_nxt.element_count      = cfg_data[30:0];
        CFG_SEND_RING_POS: cfg_nxt.send_ring_position = cfg_data[5:0];
        CFG_RECV_RING_POS: cfg_nxt.recv_ring_position = cfg_data[5:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rank_count         <= 7'd2;
      cfg_r.channel_count      <= 6'd1;
      cfg_r.channel_index      <= 5'd0;
      cfg_r.thread_count       <= 11'd512;
      cfg_r.element_count      <= 31'd1;
      cfg_r.send_ring_position <= 6'd0;
      cfg_r.recv_ring_position <= 6'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rarc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  rarc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rarc_back #(
    .MAX_RANKS      (MAX_RANKS),
    .CHUNK_ELEMENTS (CHUNK_ELEMENTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
